@@ hdl/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// Priority pixel compositor package
// Shared widths, register codes, operation codes and the grid size type.
// ----------------------------------------------------------------------------
package ppc_pkg;

  localparam int MAX_DIM_DEF      = 256;
  localparam int OPACITY_BITS_DEF = 16;

  localparam int COORD_W = 16;
  localparam int ELEM_W  = 8;
  localparam int SUM_W   = 18;   // two 16-bit signed terms plus an 8-bit unsigned one
  localparam int VALUE_W = 31;
  localparam int OPIN_W  = 16;
  localparam int CFG_W   = 9;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [CFG_W-1:0] GRID_RESET = 9'd256;

  // Register index as decoded from the word address.
  localparam logic REG_GRID_ROWS = 1'b0;
  localparam logic REG_GRID_COLS = 1'b1;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } grid_cfg_t;

endpackage

@@ hdl/priority_pixel_compositor_top.sv @@
// ----------------------------------------------------------------------------
// Priority pixel compositor
// Depth-test style compositing of mesh elements into a frame store.
// ----------------------------------------------------------------------------
// A word is accepted when start is high and busy is low. Each word yields
// exactly one result word, shown on cell_value and clipped for the single
// cycle in which done is high; the receiver cannot stall it, so it must take
// the result in that cycle. The block works on one word at a time: a word
// whose cell lies inside the grid passes through address sum, clip test,
// row-times-width multiply, the frame store's registered read, then compare
// and write-back through the store's single write port before the next word
// can be accepted; a clipped word ends after the clip test. After reset all
// MAX_DIM*MAX_DIM frame store entries (65536 at the default size) are swept
// to zero, one entry a cycle; busy stays high throughout, while register
// writes are still taken. Draws return a value of zero; reads return the
// stored value of the cell. The grid size should be changed only while idle.
// ----------------------------------------------------------------------------
module priority_pixel_compositor_top #(
  parameter int MAX_DIM      = ppc_pkg::MAX_DIM_DEF,
  parameter int OPACITY_BITS = ppc_pkg::OPACITY_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op,
  input  logic signed [ppc_pkg::COORD_W-1:0]  origin_row,
  input  logic signed [ppc_pkg::COORD_W-1:0]  origin_col,
  input  logic signed [ppc_pkg::COORD_W-1:0]  shift_row,
  input  logic signed [ppc_pkg::COORD_W-1:0]  shift_col,
  input  logic [ppc_pkg::ELEM_W-1:0]          elem_row,
  input  logic [ppc_pkg::ELEM_W-1:0]          elem_col,
  input  logic [ppc_pkg::OPIN_W-1:0]          opacity,
  input  logic [ppc_pkg::VALUE_W-1:0]         pixel_value,
  output logic [ppc_pkg::VALUE_W-1:0]         cell_value,
  output logic                               clipped,
  output logic                               done,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppc_pkg::PADDR_W-1:0]         paddr,
  input  logic [ppc_pkg::APB_W-1:0]           pwdata,
  output logic [ppc_pkg::APB_W-1:0]           prdata,
  output logic                               pready
);
  import ppc_pkg::*;

  // The store holds MAX_DIM*MAX_DIM keys, each the opacity above the value,
  // so one unsigned compare gives the opacity-first, value-second ordering.
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = OPACITY_BITS + VALUE_W;

  grid_cfg_t         cfg;
  logic              clearing;
  logic              mem_rd_en;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_wr_data;
  logic [DATA_W-1:0] mem_rd_data;

  ppc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Only one word is in flight, so the read and the write-back of a cell
  // can never overlap with another word's access to the same entry.
  ppc_engine #(
    .MAX_DIM      (MAX_DIM),
    .OPACITY_BITS (OPACITY_BITS),
    .ADDR_W       (ADDR_W),
    .DATA_W       (DATA_W)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .origin_row  (origin_row),
    .origin_col  (origin_col),
    .shift_row   (shift_row),
    .shift_col   (shift_col),
    .elem_row    (elem_row),
    .elem_col    (elem_col),
    .opacity     (opacity),
    .pixel_value (pixel_value),
    .cell_value  (cell_value),
    .clipped     (clipped),
    .done        (done),
    .clearing    (clearing),
    .mem_rd_en   (mem_rd_en),
    .mem_wr_en   (mem_wr_en),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data)
  );

  ppc_frame_store #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH),
    .DATA_W (DATA_W)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (mem_rd_en),
    .rd_addr  (mem_addr),
    .rd_data  (mem_rd_data),
    .wr_en    (mem_wr_en),
    .wr_addr  (mem_addr),
    .wr_data  (mem_wr_data),
    .clearing (clearing)
  );

endmodule

@@ hdl/ppc_regs.sv @@
// ----------------------------------------------------------------------------
// Priority pixel compositor configuration registers
// APB-style slave holding the grid row and column counts.
// ----------------------------------------------------------------------------
module ppc_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppc_pkg::PADDR_W-1:0] paddr,
  input  logic [ppc_pkg::APB_W-1:0]   pwdata,
  output logic [ppc_pkg::APB_W-1:0]   prdata,
  output logic                       pready,
  output ppc_pkg::grid_cfg_t          cfg
);
  import ppc_pkg::*;

  logic wr_en;
  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rows <= GRID_RESET;
      cfg.cols <= GRID_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        REG_GRID_ROWS: cfg.rows <= pwdata[CFG_W-1:0];
        REG_GRID_COLS: cfg.cols <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_GRID_ROWS: prdata = {{(APB_W-CFG_W){1'b0}}, cfg.rows};
      REG_GRID_COLS: prdata = {{(APB_W-CFG_W){1'b0}}, cfg.cols};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ hdl/ppc_frame_store.sv @@
// ----------------------------------------------------------------------------
// Priority pixel compositor frame store
// Single-port-write, registered-read memory of opacity/value keys with a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module ppc_frame_store #(
  parameter int ADDR_W = 16,
  parameter int DEPTH  = 65536,
  parameter int DATA_W = 47
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  output logic              clearing
);
  import ppc_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [ADDR_W-1:0] clr_addr;

  // The sweep writes zero to one entry a cycle until the last one is done.
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/ppc_engine.sv @@
// ----------------------------------------------------------------------------
// Priority pixel compositor engine
// Cell address generation, clipping and the read-compare-write sequence.
// ----------------------------------------------------------------------------
module ppc_engine #(
  parameter int MAX_DIM      = ppc_pkg::MAX_DIM_DEF,
  parameter int OPACITY_BITS = ppc_pkg::OPACITY_BITS_DEF,
  parameter int ADDR_W       = 16,
  parameter int DATA_W       = 47
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ppc_pkg::grid_cfg_t                  cfg,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op,
  input  logic signed [ppc_pkg::COORD_W-1:0]  origin_row,
  input  logic signed [ppc_pkg::COORD_W-1:0]  origin_col,
  input  logic signed [ppc_pkg::COORD_W-1:0]  shift_row,
  input  logic signed [ppc_pkg::COORD_W-1:0]  shift_col,
  input  logic [ppc_pkg::ELEM_W-1:0]          elem_row,
  input  logic [ppc_pkg::ELEM_W-1:0]          elem_col,
  input  logic [ppc_pkg::OPIN_W-1:0]          opacity,
  input  logic [ppc_pkg::VALUE_W-1:0]         pixel_value,
  output logic [ppc_pkg::VALUE_W-1:0]         cell_value,
  output logic                               clipped,
  output logic                               done,
  input  logic                               clearing,
  output logic                               mem_rd_en,
  output logic                               mem_wr_en,
  output logic [ADDR_W-1:0]                  mem_addr,
  output logic [DATA_W-1:0]                  mem_wr_data,
  input  logic [DATA_W-1:0]                  mem_rd_data
);
  import ppc_pkg::*;

  localparam int DW_RAW = $clog2(MAX_DIM + 1);
  localparam int DW     = (DW_RAW > CFG_W) ? DW_RAW : CFG_W;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LIN_W  = IDX_W + DW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ADDR,
    ST_READ,
    ST_WB
  } state_t;

  state_t                   state;
  logic                     is_read;
  logic signed [SUM_W-1:0]  row_sum;
  logic signed [SUM_W-1:0]  col_sum;
  logic signed [SUM_W-1:0]  row_next;
  logic signed [SUM_W-1:0]  col_next;
  logic signed [SUM_W-1:0]  o_row, o_col, s_row, s_col, e_row, e_col;
  logic [OPACITY_BITS-1:0]  opac;
  logic [VALUE_W-1:0]       pix;
  logic [DW-1:0]            rows_eff;
  logic [DW-1:0]            cols_eff;
  logic [DW-1:0]            cols;
  logic                     in_grid;
  logic [LIN_W-1:0]         prod;
  logic [LIN_W-1:0]         lin;
  logic [ADDR_W-1:0]        addr;
  logic [DATA_W-1:0]        new_key;
  logic                     accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE) || clearing;

  assign o_row = SUM_W'(origin_row);
  assign o_col = SUM_W'(origin_col);
  assign s_row = SUM_W'(shift_row);
  assign s_col = SUM_W'(shift_col);
  assign e_row = $signed({{(SUM_W-ELEM_W){1'b0}}, elem_row});
  assign e_col = $signed({{(SUM_W-ELEM_W){1'b0}}, elem_col});
  assign row_next = o_row + s_row + e_row;
  assign col_next = o_col + s_col + e_col;

  // A size above the store's dimension is treated as the full dimension.
  assign rows_eff = (DW'(cfg.rows) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg.rows);
  assign cols_eff = (DW'(cfg.cols) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(cfg.cols);

  assign in_grid = !row_sum[SUM_W-1] && !col_sum[SUM_W-1] &&
                   ($unsigned(row_sum) < SUM_W'(rows_eff)) &&
                   ($unsigned(col_sum) < SUM_W'(cols_eff));

  assign prod = LIN_W'(row_sum[IDX_W-1:0]) * LIN_W'(cols);
  assign lin  = prod + {{DW{1'b0}}, col_sum[IDX_W-1:0]};

  assign new_key     = {opac, pix};
  assign mem_addr    = addr;
  assign mem_wr_data = new_key;
  assign mem_rd_en   = (state == ST_READ);
  assign mem_wr_en   = (state == ST_WB) && !is_read && (new_key > mem_rd_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            is_read <= (op == OP_READ);
            row_sum <= row_next;
            col_sum <= col_next;
            opac    <= OPACITY_BITS'(opacity);
            pix     <= pixel_value;
            state   <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cols <= cols_eff;
          if (in_grid) begin
            state <= ST_ADDR;
          end else begin
            done       <= 1'b1;
            clipped    <= 1'b1;
            cell_value <= '0;
            state      <= ST_IDLE;
          end
        end
        ST_ADDR: begin
          addr  <= lin[ADDR_W-1:0];
          state <= ST_READ;
        end
        ST_READ: begin
          state <= ST_WB;
        end
        ST_WB: begin
          done       <= 1'b1;
          clipped    <= 1'b0;
          cell_value <= is_read ? mem_rd_data[VALUE_W-1:0] : '0;
          state      <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/ppc_checker.sv @@
// ----------------------------------------------------------------------------
// Priority pixel compositor checker
// Port-level properties of the command handshake and the result strobe.
// ----------------------------------------------------------------------------
module ppc_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic                       clipped,
  input logic [ppc_pkg::VALUE_W-1:0] cell_value
);
  import ppc_pkg::*;

  // The frame store sweep holds the block busy straight after reset.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low in the cycle after reset");

  // An accepted word keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a word");

  // A result appears only once the block has finished with its word.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // One word, one result: the result strobe is never held high.
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // A clipped cell never carries a value.
  a_clip_zero: assert property (@(posedge clk) disable iff (rst)
    (done && clipped) |-> (cell_value == '0))
    else $error("clipped result with a non-zero value");

endmodule

bind priority_pixel_compositor_top ppc_checker u_ppc_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .clipped    (clipped),
  .cell_value (cell_value)
);
